@@ src/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Types, constants and the arctangent table shared by the quaternion to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  // Angles travel in degrees with this many fraction bits.
  localparam int ANG_FRAC = 20;
  localparam int ATAN_LEN = 24;
  localparam int DEG_W    = 9;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } qte_in_t;

  typedef struct packed {
    logic [DEG_W-1:0] roll_deg;
    logic [DEG_W-1:0] pitch_deg;
    logic [DEG_W-1:0] yaw_deg;
  } qte_out_t;

  // atan(2^-i) in degrees, scaled by 2^ANG_FRAC.
  function automatic logic [31:0] atan_tab(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:       r = 32'd47185920;
      1:       r = 32'd27855475;
      2:       r = 32'd14718068;
      3:       r = 32'd7471121;
      4:       r = 32'd3750058;
      5:       r = 32'd1876857;
      6:       r = 32'd938658;
      7:       r = 32'd469357;
      8:       r = 32'd234682;
      9:       r = 32'd117342;
      10:      r = 32'd58671;
      11:      r = 32'd29335;
      12:      r = 32'd14668;
      13:      r = 32'd7334;
      14:      r = 32'd3667;
      15:      r = 32'd1833;
      16:      r = 32'd917;
      17:      r = 32'd458;
      18:      r = 32'd229;
      19:      r = 32'd115;
      20:      r = 32'd57;
      21:      r = 32'd29;
      22:      r = 32'd14;
      23:      r = 32'd7;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

@@ src/qte_atan2.sv @@
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined atan2 in degrees: operand normalization, quadrant fold, vectoring
// CORDIC, clamp to +/-LIM_DEG and offset by 180 to whole degrees.
// ----------------------------------------------------------------------------
module qte_atan2 #(
  parameter int CORDIC_STAGES = 16,
  parameter int LIM_DEG       = 180
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [63:0]          y_i,
  input  logic signed [63:0]          x_i,
  output logic [qte_pkg::DEG_W-1:0]   deg_o
);
  import qte_pkg::*;

  localparam int XW      = 44;
  localparam int ZW      = 32;
  localparam int N       = CORDIC_STAGES;
  localparam int NORM    = 11;
  localparam int NS      = NORM + 2 + N;
  localparam int LIM     = LIM_DEG * (2 ** ANG_FRAC);
  localparam int HALF    = 180 * (2 ** ANG_FRAC);
  localparam int DEG90   = 90 * (2 ** ANG_FRAC);

  logic signed [63:0]    nx_q [NORM+1];
  logic signed [63:0]    ny_q [NORM+1];
  logic [63:0]           nm_q [NORM+1];
  logic                  sp_q [NS];
  logic signed [ZW-1:0]  spz_q [NS];
  logic signed [XW-1:0]  cx_q [N+1];
  logic signed [XW-1:0]  cy_q [N+1];
  logic signed [ZW-1:0]  cz_q [N+1];
  logic [DEG_W-1:0]      deg_q;

  logic [63:0]           ax, ay;
  logic signed [ZW-1:0]  spz_d;

  // Axis and zero vectors bypass the CORDIC with an exact answer.
  always_comb begin
    ax = x_i[63] ? 64'(-x_i) : 64'(x_i);
    ay = y_i[63] ? 64'(-y_i) : 64'(y_i);
    if (y_i == 64'sd0) begin
      spz_d = x_i[63] ? ZW'(2 * DEG90) : '0;
    end else begin
      spz_d = y_i[63] ? ZW'(-DEG90) : ZW'(DEG90);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q[0]  <= x_i;
      ny_q[0]  <= y_i;
      nm_q[0]  <= (ax > ay) ? ax : ay;
      sp_q[0]  <= (y_i == 64'sd0) || (x_i == 64'sd0);
      spz_q[0] <= spz_d;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_sp
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sp_q[k]  <= sp_q[k-1];
        spz_q[k] <= spz_q[k-1];
      end
    end
  end

  // Binary normalization: the larger magnitude is brought into [2^38, 2^40),
  // first by right shifts of 16, 8, 4, 2, 1, then by left shifts of 32 down to 1.
  for (genvar j = 0; j < NORM; j++) begin : g_norm
    localparam bit RIGHT = (j < 5);
    localparam int SH    = RIGHT ? (16 >> j) : (32 >> (RIGHT ? 0 : j - 5));
    localparam logic [63:0] LIM_R = 64'(1) << (39 + SH);
    localparam logic [63:0] LIM_L = 64'(1) << (39 - SH);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (RIGHT && (nm_q[j] >= LIM_R)) begin
          nx_q[j+1] <= nx_q[j] >>> SH;
          ny_q[j+1] <= ny_q[j] >>> SH;
          nm_q[j+1] <= nm_q[j] >> SH;
        end else if (!RIGHT && (nm_q[j] < LIM_L)) begin
          nx_q[j+1] <= nx_q[j] <<< SH;
          ny_q[j+1] <= ny_q[j] <<< SH;
          nm_q[j+1] <= nm_q[j] << SH;
        end else begin
          nx_q[j+1] <= nx_q[j];
          ny_q[j+1] <= ny_q[j];
          nm_q[j+1] <= nm_q[j];
        end
      end
    end
  end

  logic signed [XW-1:0] px, py;
  assign px = XW'(nx_q[NORM]);
  assign py = XW'(ny_q[NORM]);

  // A left half plane vector is turned by 90 degrees into the right half plane.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (px[XW-1]) begin
        if (!py[XW-1]) begin
          cx_q[0] <= py;
          cy_q[0] <= -px;
          cz_q[0] <= ZW'(DEG90);
        end else begin
          cx_q[0] <= -py;
          cy_q[0] <= px;
          cz_q[0] <= ZW'(-DEG90);
        end
      end else begin
        cx_q[0] <= px;
        cy_q[0] <= py;
        cz_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ANG = $signed(atan_tab(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy_q[i][XW-1]) begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + ANG;
        end else begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - ANG;
        end
      end
    end
  end

  logic signed [ZW-1:0] zf, zc, zs;
  always_comb begin
    zf = sp_q[NS-1] ? spz_q[NS-1] : cz_q[N];
    zc = zf;
    if (zf > ZW'(LIM)) begin
      zc = ZW'(LIM);
    end
    if (zf < ZW'(-LIM)) begin
      zc = ZW'(-LIM);
    end
    zs = zc + ZW'(HALF);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q <= zs[ANG_FRAC +: DEG_W];
    end
  end

  assign deg_o = deg_q;

endmodule

@@ src/quaternion_to_euler_degrees.sv @@
// The integer square root resolves one root bit per register stage.
// Throughput: one item per cycle; the whole pipeline halts while a result waits.
// Reset clears only the valid bits; the data path holds no reset state.
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees
// Converts one orientation quaternion per item into roll, pitch and yaw in
// whole degrees offset by 180, using pipelined square root and CORDIC units.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int CORDIC_STAGES  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qte_pkg::qte_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qte_pkg::qte_out_t out_item_o
);
  import qte_pkg::*;

  localparam int SQ_N  = 31;
  localparam int DL_N  = SQ_N + 2;
  localparam int TOT   = CORDIC_STAGES + 49;
  localparam int SQ_ST = 4 + SQ_N;
  localparam int SH_R  = (2 * QUAT_FRAC_BITS >= 30) ? 2 * QUAT_FRAC_BITS - 30 : 0;
  localparam int SH_L  = (2 * QUAT_FRAC_BITS < 30) ? 30 - 2 * QUAT_FRAC_BITS : 0;
  localparam logic signed [63:0] ONE = 64'sd1 <<< (2 * QUAT_FRAC_BITS);

  typedef struct packed {
    logic signed [63:0] rn;
    logic signed [63:0] rd;
    logic signed [63:0] yn;
    logic signed [63:0] yd;
    logic signed [31:0] s30;
  } qte_dl_t;

  logic          adv;
  logic [TOT:1]  vld_q;

  assign adv        = !vld_q[TOT] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[TOT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOT-1:1], in_valid_i};
    end
  end

  // Stage 1: the nine products.
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q;
  logic signed [31:0] p_wy_q, p_zx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_wx_q <= in_item_i.quat_w * in_item_i.quat_x;
      p_yz_q <= in_item_i.quat_y * in_item_i.quat_z;
      p_xx_q <= in_item_i.quat_x * in_item_i.quat_x;
      p_yy_q <= in_item_i.quat_y * in_item_i.quat_y;
      p_wz_q <= in_item_i.quat_w * in_item_i.quat_z;
      p_xy_q <= in_item_i.quat_x * in_item_i.quat_y;
      p_zz_q <= in_item_i.quat_z * in_item_i.quat_z;
      p_wy_q <= in_item_i.quat_w * in_item_i.quat_y;
      p_zx_q <= in_item_i.quat_z * in_item_i.quat_x;
    end
  end

  // Stage 2: product sums, and the clamped asin argument rescaled to Q30.
  logic signed [63:0] s_raw, s_cl, s_sh;
  qte_dl_t            st2_d, st2_q;

  always_comb begin
    s_raw = (sx32(p_wy_q) - sx32(p_zx_q)) <<< 1;
    s_cl  = s_raw;
    if (s_raw > ONE) begin
      s_cl = ONE;
    end
    if (s_raw < -ONE) begin
      s_cl = -ONE;
    end
    s_sh      = (s_cl >>> SH_R) <<< SH_L;
    st2_d.rn  = (sx32(p_wx_q) + sx32(p_yz_q)) <<< 1;
    st2_d.rd  = ONE - ((sx32(p_xx_q) + sx32(p_yy_q)) <<< 1);
    st2_d.yn  = (sx32(p_wz_q) + sx32(p_xy_q)) <<< 1;
    st2_d.yd  = ONE - ((sx32(p_yy_q) + sx32(p_zz_q)) <<< 1);
    st2_d.s30 = s_sh[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st2_q <= st2_d;
    end
  end

  // Stage 3: s squared; stage 4: the square root radicand 1 - s^2 in Q60.
  logic signed [63:0] sq_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q <= st2_q.s30 * st2_q.s30;
    end
  end

  logic [61:0] rt_v_q [SQ_N+1];
  logic [61:0] rt_r_q [SQ_N+1];
  logic [63:0] rad;

  assign rad = (64'd1 << 60) - 64'(sq_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_v_q[0] <= rad[61:0];
      rt_r_q[0] <= '0;
    end
  end

  // One root bit per stage, restoring digit recurrence.
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
    logic [61:0] t;
    assign t = rt_r_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rt_v_q[k] >= t) begin
          rt_v_q[k+1] <= rt_v_q[k] - t;
          rt_r_q[k+1] <= (rt_r_q[k] >> 1) + BIT;
        end else begin
          rt_v_q[k+1] <= rt_v_q[k];
          rt_r_q[k+1] <= rt_r_q[k] >> 1;
        end
      end
    end
  end

  // Roll, yaw and the asin argument wait here for the square root.
  qte_dl_t dl_q [DL_N];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q[0] <= st2_q;
    end
  end
  for (genvar k = 1; k < DL_N; k++) begin : g_dl
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  logic signed [63:0] pitch_x;
  assign pitch_x = {33'd0, rt_r_q[SQ_N][30:0]};

  qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .LIM_DEG(180)) u_roll (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (dl_q[DL_N-1].rn),
    .x_i   (dl_q[DL_N-1].rd),
    .deg_o (out_item_o.roll_deg)
  );

  qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .LIM_DEG(90)) u_pitch (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (sx32(dl_q[DL_N-1].s30)),
    .x_i   (pitch_x),
    .deg_o (out_item_o.pitch_deg)
  );

  qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .LIM_DEG(180)) u_yaw (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (dl_q[DL_N-1].yn),
    .x_i   (dl_q[DL_N-1].yd),
    .deg_o (out_item_o.yaw_deg)
  );

`ifndef SYNTHESIS
  // A held pipeline neither drops nor creates items.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.pitch_deg >= 9'd90 && out_item_o.pitch_deg <= 9'd270))
    else $error("pitch out of range");

  a_ry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.roll_deg <= 9'd360 && out_item_o.yaw_deg <= 9'd360))
    else $error("roll or yaw out of range");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ_ST] |-> (rt_r_q[SQ_N] <= (62'd1 << 30)))
    else $error("square root exceeds one");
`endif

endmodule
